[sv/sfll_pkg.sv]
// ----------------------------------------------------------------------------
// sfll_pkg
// Shared constants and channel types of the SOGI-FLL core.
// ----------------------------------------------------------------------------
package sfll_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int INT_W      = 32;
	localparam int EXTRA_BITS = 8;
	localparam int FREQ_W     = 24;
	localparam int GAIN_W     = 16;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int OUT_W      = 2 * SAMPLE_W + FREQ_W;

	// shared multiplier: 64 x 32 in two 32 x 32 halves
	localparam int MUL_AW = 64;
	localparam int MUL_BW = 32;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// reciprocal divider: 59-bit dividend, 36-bit divisor, 30-bit quotient
	localparam int DIV_NW = 59;
	localparam int DIV_DW = 36;
	localparam int DIV_QW = 30;

	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

	localparam logic [CFG_W-1:0]  SAMPLE_PERIOD_RST = 24'd1481023;
	localparam logic [CFG_W-1:0]  NOMINAL_FREQ_RST  = 24'd80425;
	localparam logic [GAIN_W-1:0] DAMPING_GAIN_RST  = 16'd23170;
	localparam logic [GAIN_W-1:0] LOOP_GAIN_RST     = 16'd10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_PERIOD,
		REG_NOMINAL_FREQ,
		REG_DAMPING_GAIN,
		REG_LOOP_GAIN
	} cfg_reg_t;

	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [MUL_PW-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_QW-1:0] q;
	} div_rsp_t;

endpackage

[sv/sfll_mul.sv]
// ----------------------------------------------------------------------------
// sfll_mul
// Shared unsigned multiplier, 64 x 32 bits over two 32 x 32 passes.
// ----------------------------------------------------------------------------
module sfll_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  sfll_pkg::mul_req_t req,
	output sfll_pkg::mul_rsp_t rsp
);
	import sfll_pkg::*;

	localparam int HW = MUL_AW / 2;

	typedef enum logic [1:0] {M_IDLE, M_HI, M_SUM} mstate_t;

	mstate_t           state_q;
	logic [HW-1:0]     a_hi_q;
	logic [MUL_BW-1:0] b_q;
	logic [HW+MUL_BW-1:0] part_q;
	logic [HW+MUL_BW-1:0] lo_q;
	logic [MUL_PW-1:0] p_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_hi_q  <= req.a[MUL_AW-1:HW];
						b_q     <= req.b;
						part_q  <= {{MUL_BW{1'b0}}, req.a[HW-1:0]} * {{HW{1'b0}}, req.b};
						state_q <= M_HI;
					end
				end
				M_HI: begin
					lo_q    <= part_q;
					part_q  <= {{MUL_BW{1'b0}}, a_hi_q} * {{HW{1'b0}}, b_q};
					state_q <= M_SUM;
				end
				M_SUM: begin
					p_q     <= {part_q, {HW{1'b0}}} + {{HW{1'b0}}, lo_q};
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = p_q;

endmodule

[sv/sfll_div.sv]
// ----------------------------------------------------------------------------
// sfll_div
// Restoring divider, one quotient bit per cycle, quotient known below 2^30.
// ----------------------------------------------------------------------------
module sfll_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sfll_pkg::div_req_t req,
	output sfll_pkg::div_rsp_t rsp
);
	import sfll_pkg::*;

	localparam int CNT_W = $clog2(DIV_QW);
	localparam int HI_W  = DIV_NW - DIV_QW;

	typedef enum logic {D_IDLE, D_RUN} dstate_t;

	dstate_t           state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_QW-1:0] low_q;
	logic [DIV_QW-1:0] q_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, low_q[DIV_QW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						// top bits sit below the divisor since the quotient is narrow
						rem_q   <= {{(DIV_DW-HI_W){1'b0}}, req.num[DIV_NW-1:DIV_QW]};
						low_q   <= req.num[DIV_QW-1:0];
						den_q   <= req.den;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
					q_q   <= {q_q[DIV_QW-2:0], ge};
					low_q <= {low_q[DIV_QW-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_QW - 1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = q_q;

endmodule

[sv/sogi_quadrature_fll_core.sv]
// ----------------------------------------------------------------------------
// sogi_quadrature_fll_core
// SOGI quadrature generator with frequency-locked loop, fixed point.
// ----------------------------------------------------------------------------
// operation: each sample runs 17 products on the shared multiplier, with the
//   reciprocal divide after the third product and output saturation before
//   the last three, then the loop update, which holds while the previous
//   result still waits in the output register
// throughput: the next sample is taken only once the previous result has
//   been written to the output register
// reset: arst_n clears history and frequency correction, frequency estimate
//   and registers return to their defaults, no result pending
module sogi_quadrature_fll_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [sfll_pkg::SAMPLE_W-1:0] s_axis_tdata,  // sample
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [sfll_pkg::OUT_W-1:0]    m_axis_tdata,  // in_phase, quadrature, freq_estimate
	input  logic                          cfg_we,
	input  logic [sfll_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfll_pkg::CFG_W-1:0]    cfg_data
);
	import sfll_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT,
		ST_FIN1, ST_FIN2, ST_UPD1, ST_UPD2
	} state_t;

	// product sequence on the shared multiplier
	typedef enum logic [4:0] {
		OP_FTS, OP_XX, OP_KX, OP_KX2, OP_C0, OP_C1, OP_C2, OP_CB,
		OP_A0, OP_A1, OP_A2, OP_B0, OP_B1, OP_B2, OP_EB, OP_KI, OP_TS
	} op_t;

	localparam logic [26:0] X_MAX = 27'd1 << 26;  // 4 rad per sample in Q.24
	localparam logic signed [26:0] S_MAX  = 27'sd32767;
	localparam logic signed [26:0] S_MIN  = -27'sd32768;
	localparam logic signed [26:0] E_MAX  = 27'sd65535;
	localparam logic signed [26:0] E_MIN  = -27'sd65536;

	// ---- helpers
	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic signed [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

	function automatic logic [35:0] mag37(input logic signed [36:0] v);
		logic signed [36:0] n;
		n = -v;
		return v[36] ? n[35:0] : v[35:0];
	endfunction

	function automatic logic signed [INT_W-1:0] sat40(input logic signed [39:0] v);
		if (v > 40'sh007fffffff) return 32'sh7fffffff;
		if (v < -40'sh0080000000) return 32'sh80000000;
		return v[INT_W-1:0];
	endfunction

	// round half away from zero by 2^EXTRA_BITS
	function automatic logic signed [26:0] rshift8(input logic signed [33:0] v);
		logic signed [33:0] n;
		logic [33:0] m;
		logic [33:0] t;
		logic signed [26:0] r;
		n = -v;
		m = v[33] ? n : v;
		t = m + 34'd128;
		r = $signed({1'b0, t[33:EXTRA_BITS]});
		return v[33] ? -r : r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [26:0] v);
		if (v > S_MAX) return 16'sh7fff;
		if (v < S_MIN) return 16'sh8000;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W:0] sat17(input logic signed [26:0] v);
		if (v > E_MAX) return 17'sh0ffff;
		if (v < E_MIN) return 17'sh10000;
		return v[SAMPLE_W:0];
	endfunction

	// ---- configuration registers
	logic [CFG_W-1:0]  ts_q;
	logic [FREQ_W-1:0] w0_q;
	logic [GAIN_W-1:0] k_q;
	logic [GAIN_W-1:0] ki_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= SAMPLE_PERIOD_RST;
			w0_q <= NOMINAL_FREQ_RST;
			k_q  <= DAMPING_GAIN_RST;
			ki_q <= LOOP_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SAMPLE_PERIOD: ts_q <= cfg_data;
				REG_NOMINAL_FREQ:  w0_q <= cfg_data[FREQ_W-1:0];
				REG_DAMPING_GAIN:  k_q  <= cfg_data[GAIN_W-1:0];
				REG_LOOP_GAIN:     ki_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- filter and loop state
	state_t state_q;
	op_t    op_q;

	logic signed [SAMPLE_W-1:0] s_q, s1_q, s2_q;
	logic signed [INT_W-1:0]    a1_q, a2_q, b1_q, b2_q;
	logic signed [31:0]         fc_q;     // frequency correction, Q.8
	logic [FREQ_W-1:0]          freq_q;   // present estimate, Q16.8

	// per-sample working registers
	logic [26:0]                x_q;      // w*Ts, Q.24
	logic [32:0]                x2_q;     // x^2, Q.28
	logic [34:0]                kx2_q;    // 2Kx, Q.28
	logic [34:0]                nb_q;     // K x^2, Q.28
	logic [DIV_QW-1:0]          recip_q;
	logic signed [31:0]         c0_q, c1_q, c2_q, cb_q;
	logic signed [39:0]         asum_q, bsum_q;
	logic signed [INT_W-1:0]    alpha_q, beta_q;
	logic signed [SAMPLE_W-1:0] aout_q, bout_q;
	logic signed [SAMPLE_W:0]   err_q;
	logic [47:0]                m1_q;
	logic [19:0]                dw_q;

	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;
	div_req_t dreq;
	div_rsp_t drsp;

	sfll_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	sfll_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// ---- coefficient numerators and filter inputs
	logic [35:0]         nden;
	logic signed [36:0]  n1, n2;
	logic signed [16:0]  diff_a;
	logic signed [17:0]  sum_b;
	logic signed [24:0]  va;
	logic signed [25:0]  vb;

	always_comb begin
		nden   = {3'd0, x2_q} + (36'd1 << 30) + {1'b0, kx2_q};
		n1     = $signed(37'd1 << 31) - $signed({3'd0, x2_q, 1'b0});
		n2     = $signed({2'd0, kx2_q}) - $signed({4'd0, x2_q}) - $signed(37'd1 << 30);
		diff_a = 17'(s_q) - 17'(s2_q);
		sum_b  = 18'(s_q) + $signed({s1_q[SAMPLE_W-1], s1_q, 1'b0}) + 18'(s2_q);
		va     = $signed({diff_a, 8'd0});
		vb     = $signed({sum_b, 8'd0});
	end

	// ---- operand select for the shared multiplier
	logic op_neg;  // sign of the product or coefficient

	always_comb begin
		mreq.start = (state_q == ST_MUL_GO);
		mreq.a     = '0;
		mreq.b     = '0;
		op_neg     = 1'b0;
		case (op_q)
			OP_FTS: begin
				mreq.a = {40'd0, freq_q};
				mreq.b = {8'd0, ts_q};
			end
			OP_XX: begin
				mreq.a = {37'd0, x_q};
				mreq.b = {5'd0, x_q};
			end
			OP_KX: begin
				mreq.a = {37'd0, x_q};
				mreq.b = {16'd0, k_q};
			end
			OP_KX2: begin
				mreq.a = {31'd0, x2_q};
				mreq.b = {16'd0, k_q};
			end
			OP_C0: begin
				mreq.a = {29'd0, kx2_q};
				mreq.b = {2'd0, recip_q};
			end
			OP_C1: begin
				mreq.a = {28'd0, mag37(n1)};
				mreq.b = {2'd0, recip_q};
				op_neg = n1[36];
			end
			OP_C2: begin
				mreq.a = {28'd0, mag37(n2)};
				mreq.b = {2'd0, recip_q};
				op_neg = n2[36];
			end
			OP_CB: begin
				mreq.a = {29'd0, nb_q};
				mreq.b = {2'd0, recip_q};
			end
			OP_A0: begin
				mreq.a = {32'd0, mag33(33'(va))};
				mreq.b = mag33(33'(c0_q));
				op_neg = va[24] ^ c0_q[31];
			end
			OP_A1: begin
				mreq.a = {32'd0, mag33(33'(a1_q))};
				mreq.b = mag33(33'(c1_q));
				op_neg = a1_q[INT_W-1] ^ c1_q[31];
			end
			OP_A2: begin
				mreq.a = {32'd0, mag33(33'(a2_q))};
				mreq.b = mag33(33'(c2_q));
				op_neg = a2_q[INT_W-1] ^ c2_q[31];
			end
			OP_B0: begin
				mreq.a = {32'd0, mag33(33'(vb))};
				mreq.b = mag33(33'(cb_q));
				op_neg = vb[25] ^ cb_q[31];
			end
			OP_B1: begin
				mreq.a = {32'd0, mag33(33'(b1_q))};
				mreq.b = mag33(33'(c1_q));
				op_neg = b1_q[INT_W-1] ^ c1_q[31];
			end
			OP_B2: begin
				mreq.a = {32'd0, mag33(33'(b2_q))};
				mreq.b = mag33(33'(c2_q));
				op_neg = b2_q[INT_W-1] ^ c2_q[31];
			end
			OP_EB: begin
				mreq.a = {32'd0, mag33(33'(err_q))};
				mreq.b = mag33(33'(bout_q));
			end
			OP_KI: begin
				mreq.a = {16'd0, m1_q};
				mreq.b = {16'd0, ki_q};
			end
			OP_TS: begin
				mreq.a = {16'd0, m1_q};
				mreq.b = {8'd0, ts_q};
			end
			default: ;
		endcase
	end

	// reciprocal of the common denominator, round(2^58 / N)
	always_comb begin
		dreq.start = (state_q == ST_DIV_GO);
		dreq.num   = {1'b1, 23'd0, nden[35:1]};
		dreq.den   = nden;
	end

	// ---- rounding of the product just finished
	logic [48:0]        t_x;
	logic [32:0]        x_raw;
	logic [53:0]        t_x2;
	logic [43:0]        t_kx;
	logic [50:0]        t_nb;
	logic [64:0]        t_c;
	logic [31:0]        coef_mag;
	logic [31:0]        coef;
	logic [63:0]        t_f;
	logic [35:0]        term_mag;
	logic signed [39:0] term;
	logic [73:0]        t_dw;

	always_comb begin
		t_x      = {1'b0, mrsp.p[47:0]} + 49'd32768;
		x_raw    = t_x[48:16];
		t_x2     = {1'b0, mrsp.p[52:0]} + (54'd1 << 19);
		t_kx     = mrsp.p[43:0] + 44'd256;
		t_nb     = mrsp.p[50:0] + (51'd1 << 13);
		t_c      = {1'b0, mrsp.p[63:0]} + (65'd1 << 29);
		coef_mag = t_c[61:30];
		coef     = op_neg ? -coef_mag : coef_mag;
		t_f      = {1'b0, mrsp.p[62:0]} + (64'd1 << 27);
		term_mag = t_f[63:28];
		term     = op_neg ? -$signed({4'd0, term_mag}) : $signed({4'd0, term_mag});
		t_dw     = {1'b0, mrsp.p[72:0]} + (74'd1 << 53);
	end

	// ---- loop update
	logic               same_sign;
	logic signed [39:0] fc_sum;
	logic signed [33:0] w_sum;
	logic [FREQ_W-1:0]  w_new;

	always_comb begin
		same_sign = (err_q > 0 && bout_q > 0) || (err_q < 0 && bout_q < 0);
		fc_sum    = 40'(fc_q) + (same_sign ? -$signed({20'd0, dw_q}) : $signed({20'd0, dw_q}));
		w_sum     = $signed({10'd0, w0_q}) + 34'(fc_q);
		if (w_sum < 34'sd1) begin
			w_new = FREQ_W'(1);
		end else if (w_sum > $signed({10'd0, FREQ_MAX})) begin
			w_new = FREQ_MAX;
		end else begin
			w_new = w_sum[FREQ_W-1:0];
		end
	end

	// ---- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_FTS;
			out_valid_q <= 1'b0;
			s1_q        <= '0;
			s2_q        <= '0;
			a1_q        <= '0;
			a2_q        <= '0;
			b1_q        <= '0;
			b2_q        <= '0;
			fc_q        <= '0;
			freq_q      <= NOMINAL_FREQ_RST;
		end else begin
			// the update state refills the output register itself
			if (m_axis_tready && state_q != ST_UPD2) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						s_q     <= s_axis_tdata;
						op_q    <= OP_FTS;
						state_q <= ST_MUL_GO;
					end
				end
				ST_MUL_GO: begin
					state_q <= ST_MUL_WAIT;
				end
				ST_MUL_WAIT: begin
					if (mrsp.done) begin
						state_q <= ST_MUL_GO;
						op_q    <= op_t'(op_q + 5'd1);
						case (op_q)
							OP_FTS: x_q  <= (x_raw > 33'(X_MAX)) ? X_MAX : x_raw[26:0];
							OP_XX:  x2_q <= t_x2[52:20];
							OP_KX: begin
								kx2_q   <= t_kx[43:9];
								state_q <= ST_DIV_GO;
							end
							OP_KX2: nb_q <= t_nb[48:14];
							OP_C0:  c0_q <= coef;
							OP_C1:  c1_q <= coef;
							OP_C2:  c2_q <= coef;
							OP_CB:  cb_q <= coef;
							OP_A0:  asum_q <= term;
							OP_A1, OP_A2: asum_q <= asum_q + term;
							OP_B0:  bsum_q <= term;
							OP_B1:  bsum_q <= bsum_q + term;
							OP_B2: begin
								bsum_q  <= bsum_q + term;
								state_q <= ST_FIN1;
							end
							OP_EB, OP_KI: m1_q <= mrsp.p[47:0];
							OP_TS: begin
								dw_q    <= t_dw[73:54];
								state_q <= ST_UPD1;
							end
							default: ;
						endcase
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (drsp.done) begin
						recip_q <= drsp.q;
						state_q <= ST_MUL_GO;
					end
				end
				ST_FIN1: begin
					alpha_q <= sat40(asum_q);
					beta_q  <= sat40(bsum_q);
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					aout_q  <= sat16(rshift8(34'(alpha_q)));
					bout_q  <= sat16(rshift8(34'(beta_q)));
					err_q   <= sat17(rshift8(34'($signed({s_q, 8'd0})) - 34'(alpha_q)));
					op_q    <= OP_EB;
					state_q <= ST_MUL_GO;
				end
				ST_UPD1: begin
					fc_q    <= sat40(fc_sum);
					state_q <= ST_UPD2;
				end
				ST_UPD2: begin
					// hold here until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {w_new, bout_q, aout_q};
						freq_q      <= w_new;
						s2_q        <= s1_q;
						s1_q        <= s_q;
						a2_q        <= a1_q;
						a1_q        <= alpha_q;
						b2_q        <= b1_q;
						b1_q        <= beta_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

[sv/sfll_checker.sv]
// ----------------------------------------------------------------------------
// sfll_checker
// Port-level checks of the SOGI-FLL core, bound to the top level.
// ----------------------------------------------------------------------------
module sfll_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [sfll_pkg::OUT_W-1:0] m_axis_tdata
);
	import sfll_pkg::*;

	// busy right after an input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("core ready right after input transfer");

	// a new result appears together with readiness for the next sample
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result shown while core still busy");

	// frequency estimate never leaves its clamp range
	a_freq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_W-1:2*SAMPLE_W] != '0)
		else $error("frequency estimate is zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind sogi_quadrature_fll_core sfll_checker u_sfll_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

[tb/tb_sogi_quadrature_fll_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sogi_quadrature_fll_core
// Self-checking bench: a bit-exact fixed-point SOGI-FLL predictor feeds a
// scoreboard, samples are streamed with random gaps and output back-pressure,
// and registers are reprogrammed between phases once the core is drained.
// ----------------------------------------------------------------------------
module tb_sogi_quadrature_fll_core;
	import sfll_pkg::*;

	// expected sogi result
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] in_phase;
		logic signed [SAMPLE_W-1:0] quadrature;
		logic [FREQ_W-1:0]          freq_est;
	} sogi_res_t;

	// ------------------------------------------------------------------------
	// scoreboard: fixed-point sogi-fll predictor plus queue of pending results
	// ------------------------------------------------------------------------
	class sogi_scoreboard;
		longint unsigned ts, w0, kgain, ki;
		longint s1, s2, a1, a2, b1, b2, corr, w;
		sogi_res_t pending[$];
		int errors;

		function new();
			ts = SAMPLE_PERIOD_RST; w0 = NOMINAL_FREQ_RST;
			kgain = DAMPING_GAIN_RST; ki = LOOP_GAIN_RST;
			s1 = 0; s2 = 0; a1 = 0; a2 = 0; b1 = 0; b2 = 0; corr = 0;
			w = NOMINAL_FREQ_RST;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, longint unsigned v);
			case (idx)
				REG_SAMPLE_PERIOD: ts = v & 24'hFFFFFF;
				REG_NOMINAL_FREQ:  w0 = v & 24'hFFFFFF;
				REG_DAMPING_GAIN:  kgain = v & 16'hFFFF;
				REG_LOOP_GAIN:     ki = v & 16'hFFFF;
			endcase
		endfunction

		function longint clip(longint v, int bits);
			longint lim;
			lim = longint'(1) << (bits - 1);
			if (v > lim - 1) return lim - 1;
			if (v < -lim) return -lim;
			return v;
		endfunction

		function longint unsigned absv(longint v);
			return v < 0 ? longint'(-v) : v;
		endfunction

		function longint rnd_shift(longint v, int n);
			longint unsigned m;
			m = (absv(v) + (64'd1 << (n - 1))) >> n;
			return v < 0 ? -longint'(m) : longint'(m);
		endfunction

		// v * c / 2^28 rounded half away from zero, wide product
		function longint coef_mul(longint v, longint c);
			logic [127:0] p;
			longint unsigned m;
			p = 128'(absv(v)) * 128'(absv(c)) + (128'd1 << 27);
			m = 64'(p >> 28);
			return ((v < 0) != (c < 0)) ? -longint'(m) : longint'(m);
		endfunction

		function longint scale_coef(longint n, longint unsigned recip);
			longint unsigned q;
			q = (absv(n) * recip + (64'd1 << 29)) >> 30;
			return n < 0 ? -longint'(q) : longint'(q);
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] smp);
			longint s, x2, kx2, nden, nb, c0, c1, c2, cb, alpha, beta, ao, bo, err;
			longint unsigned x, recip, m1, dw;
			logic [127:0] wide;
			bit same;
			sogi_res_t r;
			s = smp;
			x = (longint'(w) * ts + (64'd1 << 15)) >> 16;
			if (x > (64'd4 << 24)) x = 64'd4 << 24;
			x2 = (x * x + (64'd1 << 19)) >> 20;
			kx2 = (kgain * x * 2 + (64'd1 << 9)) >> 10;
			nden = x2 + (longint'(4) << 28) + kx2;
			recip = ((64'd1 << 58) + (longint'(nden) >> 1)) / nden;
			nb = (kgain * x2 + (64'd1 << 13)) >> 14;
			c0 = scale_coef(kx2, recip);
			c1 = scale_coef((longint'(8) << 28) - 2 * x2, recip);
			c2 = scale_coef(-(x2 + (longint'(4) << 28) - kx2), recip);
			cb = scale_coef(nb, recip);
			alpha = clip(coef_mul((s - s2) * 256, c0) + coef_mul(a1, c1) + coef_mul(a2, c2),
				INT_W);
			beta = clip(coef_mul((s + 2 * s1 + s2) * 256, cb) + coef_mul(b1, c1)
				+ coef_mul(b2, c2), INT_W);
			ao = clip(rnd_shift(alpha, EXTRA_BITS), SAMPLE_W);
			bo = clip(rnd_shift(beta, EXTRA_BITS), SAMPLE_W);
			// loop update: |e|*|beta|*Ki*Ts / 2^(2*SAMPLE_W+22), rounded
			err = clip(rnd_shift(s * 256 - alpha, EXTRA_BITS), SAMPLE_W + 1);
			m1 = absv(err) * absv(bo) * ki;
			wide = 128'(m1) * 128'(ts) + (128'd1 << (2 * SAMPLE_W + 21));
			dw = 64'(wide >> (2 * SAMPLE_W + 22));
			same = (err > 0 && bo > 0) || (err < 0 && bo < 0);
			corr = clip(corr + (same ? -longint'(dw) : longint'(dw)), 32);
			w = longint'(w0) + corr;
			if (w < 1) w = 1;
			if (w > FREQ_MAX) w = FREQ_MAX;
			s2 = s1; s1 = s; a2 = a1; a1 = alpha; b2 = b1; b1 = beta;
			r.in_phase = ao[SAMPLE_W-1:0];
			r.quadrature = bo[SAMPLE_W-1:0];
			r.freq_est = w[FREQ_W-1:0];
			pending.push_back(r);
		endfunction

		function void report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			sogi_res_t e;
			logic signed [SAMPLE_W-1:0] ip, qd;
			logic [FREQ_W-1:0] fe;
			ip = data[SAMPLE_W-1:0];
			qd = data[2*SAMPLE_W-1:SAMPLE_W];
			fe = data[OUT_W-1:2*SAMPLE_W];
			if (pending.size() == 0) begin
				$display("mismatch: result with nothing pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (ip !== e.in_phase) report("in_phase", ip, e.in_phase);
			if (qd !== e.quadrature) report("quadrature", qd, e.quadrature);
			if (fe !== e.freq_est) report("freq_estimate", fe, e.freq_est);
		endfunction
	endclass

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [SAMPLE_W-1:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sogi_scoreboard sb;
	int idle_cycles = 0;
	bit hold_sink;
	bit sink_quiet;

	sogi_quadrature_fll_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// push one sample through the input channel, valid stays up until the
	// next call or drain lowers it
	task automatic send_sample(logic [SAMPLE_W-1:0] v);
		int g;
		g = sink_quiet ? 0 : gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_sample(v);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		sb.write_reg(idx, v);
	endtask

	// wait until every expected result is out, plus a latency margin
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic program_all(logic [23:0] t, logic [23:0] f, logic [15:0] k,
			logic [15:0] g);
		drain();
		write_reg(REG_SAMPLE_PERIOD, t);
		write_reg(REG_NOMINAL_FREQ, f);
		write_reg(REG_DAMPING_GAIN, 24'(k));
		write_reg(REG_LOOP_GAIN, 24'(g));
		cfg_we <= 1'b0;
	endtask

	// sine-like stimulus with random amplitude, step, noise and phase, now and then a random sample
	task automatic send_burst(int n);
		real ph, step, amp;
		int v;
		ph = $urandom_range(0, 628) / 100.0;
		step = 0.02 + $urandom_range(0, 300) / 1000.0;
		amp = $urandom_range(1000, 40000);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) v = $urandom();
			else v = $rtoi(amp * $sin(ph)) + $urandom_range(0, 400) - 200;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			send_sample(v[SAMPLE_W-1:0]);
			ph += step;
		end
	endtask

	// output side: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n || hold_sink) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(0, 9) < 7);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		sb = new();
		hold_sink = 1'b0;
		sink_quiet = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SAMPLE_PERIOD;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, steps and zeros at default settings
		send_sample(16'sh7FFF); send_sample(16'sh8000); send_sample(16'sh0000);
		send_sample(16'sh7FFF); send_sample(16'sh7FFF); send_sample(16'sh8000);
		send_sample(16'sh8000); send_sample(16'sh0001); send_sample(16'shFFFF);
		send_sample(16'sh5555); send_sample(16'shAAAA);
		// large frequency: x saturates
		program_all(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(16'sh7FFF); send_sample(16'sh8000); send_sample(16'sh7FFF);
		send_sample(16'sh1234);
		// smallest period and frequency, fixed-frequency mode
		program_all(24'd1, 24'd1, 16'd0, 16'd0);
		send_sample(16'sh7FFF); send_sample(16'sh8000); send_sample(16'sh4000);
		// nominal change followed after one sample
		program_all(24'd1481023, 24'd80425, 16'd23170, 16'd10000);
		send_sample(16'sh2000);
		program_all(24'd1481023, 24'd120000, 16'd23170, 16'd65535);
		send_sample(16'sh2000); send_sample(16'shE000); send_sample(16'sh7000);

		// random phases with varied settings
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: program_all(24'd1481023, 24'($urandom_range(60000, 100000)),
					16'($urandom_range(10000, 40000)), 16'($urandom_range(0, 65535)));
				1: program_all(24'($urandom_range(1, 24'hFFFFFF)),
					24'($urandom_range(1, 24'hFFFFFF)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
				2: program_all(24'($urandom_range(500000, 3000000)),
					24'($urandom_range(20000, 200000)),
					16'($urandom_range(0, 65535)), 16'hFFFF);
				default: program_all(24'd1481023, 24'd80425, 16'd23170, 16'd10000);
			endcase
			if (ph == 5) begin
				// long receiver hold-off while the sender keeps offering
				fork
					begin
						hold_sink = 1'b1;
						repeat (2000) @(negedge clk);
						hold_sink = 1'b0;
					end
					begin
						sink_quiet = 1'b1;
						send_burst(10);
						sink_quiet = 1'b0;
					end
				join
			end
			send_burst(100);
		end

		drain();
		if (sb.errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
